/* src/c8ie_pkg.sv */
// Shared types and opcode constants for the CHIP-8 instruction executor.
package c8ie_pkg;

    localparam logic [11:0] PC_RESET    = 12'h200;
    localparam logic [3:0]  REG_FLAG    = 4'hF;
    localparam int          QUEUE_DEPTH = 2;

    // top nibble of the opcode
    localparam logic [3:0] GRP_SYS   = 4'h0;
    localparam logic [3:0] GRP_JP    = 4'h1;
    localparam logic [3:0] GRP_CALL  = 4'h2;
    localparam logic [3:0] GRP_SE_K  = 4'h3;
    localparam logic [3:0] GRP_SNE_K = 4'h4;
    localparam logic [3:0] GRP_SE_R  = 4'h5;
    localparam logic [3:0] GRP_LD_K  = 4'h6;
    localparam logic [3:0] GRP_ADD_K = 4'h7;
    localparam logic [3:0] GRP_ALU   = 4'h8;
    localparam logic [3:0] GRP_SNE_R = 4'h9;
    localparam logic [3:0] GRP_LDI   = 4'hA;
    localparam logic [3:0] GRP_JP0   = 4'hB;

    // low nibble within the zero group and the ALU group
    localparam logic [3:0] SYS_CLS = 4'h0;
    localparam logic [3:0] SYS_RET = 4'hE;
    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;

    typedef enum logic [4:0] {
        OP_CLS,
        OP_RET,
        OP_JP,
        OP_CALL,
        OP_SE_K,
        OP_SNE_K,
        OP_SE_R,
        OP_SNE_R,
        OP_LD_K,
        OP_ADD_K,
        OP_MOV,
        OP_OR,
        OP_AND,
        OP_XOR,
        OP_ADD_R,
        OP_SUB_R,
        OP_LDI,
        OP_JP0,
        OP_UNH
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [11:0] nnn;
    } item_t;

    typedef struct packed {
        logic [11:0] next_pc;
        logic [11:0] index_value;
        logic        reg_write;
        logic [3:0]  reg_number;
        logic [7:0]  reg_value;
        logic        flag_write;
        logic        flag_value;
        logic        clear_display;
        logic        unhandled;
    } result_t;

endpackage

/* src/c8ie_front.sv */
// Front end: splits an opcode into its fields and classifies the operation.
module c8ie_front
    import c8ie_pkg::*;
(
    input  logic [15:0] instruction,
    output item_t       item
);

    logic [3:0] u;
    logic [3:0] n;

    assign u = instruction[15:12];
    assign n = instruction[3:0];

    always_comb begin
        item.x   = instruction[11:8];
        item.y   = instruction[7:4];
        item.nnn = instruction[11:0];
        case (u)
            GRP_SYS: begin
                if (n == SYS_CLS) begin
                    item.op = OP_CLS;
                end else if (n == SYS_RET) begin
                    item.op = OP_RET;
                end else begin
                    item.op = OP_UNH;
                end
            end
            GRP_JP:    item.op = OP_JP;
            GRP_CALL:  item.op = OP_CALL;
            GRP_SE_K:  item.op = OP_SE_K;
            GRP_SNE_K: item.op = OP_SNE_K;
            GRP_SE_R:  item.op = OP_SE_R;
            GRP_LD_K:  item.op = OP_LD_K;
            GRP_ADD_K: item.op = OP_ADD_K;
            GRP_ALU: begin
                case (n)
                    ALU_MOV: item.op = OP_MOV;
                    ALU_OR:  item.op = OP_OR;
                    ALU_AND: item.op = OP_AND;
                    ALU_XOR: item.op = OP_XOR;
                    ALU_ADD: item.op = OP_ADD_R;
                    ALU_SUB: item.op = OP_SUB_R;
                    default: item.op = OP_UNH;
                endcase
            end
            GRP_SNE_R: item.op = OP_SNE_R;
            GRP_LDI:   item.op = OP_LDI;
            GRP_JP0:   item.op = OP_JP0;
            default:   item.op = OP_UNH;
        endcase
    end

endmodule

/* src/c8ie_queue.sv */
// Short FIFO of decoded instructions between front end and execute stage.
module c8ie_queue
    import c8ie_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t           entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push, pop;

    assign in_ready  = (count_reg != CW'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* src/c8ie_back.sv */
// Back end: register read, execute against the machine state, result register.
module c8ie_back
    import c8ie_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    localparam int SPW = $clog2(STACK_DEPTH);

    // general registers: memory with registered reads, VF and V0 kept in flops
    logic [7:0]     vreg_mem [16];
    logic [15:0]    vvalid_reg;
    logic [7:0]     rdx_reg, rdy_reg;
    logic           rdx_ok_reg, rdy_ok_reg;
    logic           fwd_valid_reg;
    logic [3:0]     fwd_addr_reg;
    logic [7:0]     fwd_data_reg;
    logic [7:0]     v0_reg, v0_next;
    logic [7:0]     vf_reg, vf_next;

    logic           ex_valid_reg;
    item_t          ex_item_reg;
    logic [11:0]    pc_reg, pc_next;
    logic [11:0]    idx_reg, idx_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [11:0]    stack_reg [STACK_DEPTH];
    logic           out_valid_reg;
    result_t        out_reg;

    logic           ex_fire, load, mem_we;
    logic [7:0]     vx, vy, kk, rv;
    logic [8:0]     sum;
    logic [11:0]    pc2, pc4, nxt, idx_new;
    logic [SPW-1:0] sp_inc, sp_dec, sp_new;
    logic           rw, fw, fv, clr, unh, push;
    result_t        res;

    assign ex_fire   = ex_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !ex_valid_reg || ex_fire;
    assign load      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_result = out_reg;

    // a write in the cycle a read is launched is not seen by the memory; forward it
    always_comb begin
        if (ex_item_reg.x == REG_FLAG) begin
            vx = vf_reg;
        end else if (fwd_valid_reg && fwd_addr_reg == ex_item_reg.x) begin
            vx = fwd_data_reg;
        end else begin
            vx = rdx_ok_reg ? rdx_reg : 8'h00;
        end
        if (ex_item_reg.y == REG_FLAG) begin
            vy = vf_reg;
        end else if (fwd_valid_reg && fwd_addr_reg == ex_item_reg.y) begin
            vy = fwd_data_reg;
        end else begin
            vy = rdy_ok_reg ? rdy_reg : 8'h00;
        end
    end

    assign kk     = ex_item_reg.nnn[7:0];
    assign pc2    = pc_reg + 12'd2;
    assign pc4    = pc_reg + 12'd4;
    assign sum    = {1'b0, vx} + {1'b0, vy};
    assign sp_inc = (sp_reg == SPW'(STACK_DEPTH - 1)) ? '0 : sp_reg + 1'b1;
    assign sp_dec = (sp_reg == '0) ? SPW'(STACK_DEPTH - 1) : sp_reg - 1'b1;

    always_comb begin
        nxt     = pc2;
        idx_new = idx_reg;
        sp_new  = sp_reg;
        rw      = 1'b0;
        rv      = 8'h00;
        fw      = 1'b0;
        fv      = 1'b0;
        clr     = 1'b0;
        unh     = 1'b0;
        push    = 1'b0;
        case (ex_item_reg.op)
            OP_CLS: clr = 1'b1;
            OP_RET: begin
                sp_new = sp_dec;
                nxt    = stack_reg[sp_dec] + 12'd2;
            end
            OP_JP: nxt = ex_item_reg.nnn;
            OP_CALL: begin
                push   = 1'b1;
                sp_new = sp_inc;
                nxt    = ex_item_reg.nnn;
            end
            OP_SE_K:  if (vx == kk) nxt = pc4;
            OP_SNE_K: if (vx != kk) nxt = pc4;
            OP_SE_R:  if (vx == vy) nxt = pc4;
            OP_SNE_R: if (vx != vy) nxt = pc4;
            OP_LD_K: begin
                rw = 1'b1;
                rv = kk;
            end
            OP_ADD_K: begin
                rw = 1'b1;
                rv = vx + kk;
            end
            OP_MOV: begin
                rw = 1'b1;
                rv = vy;
            end
            OP_OR: begin
                rw = 1'b1;
                rv = vx | vy;
            end
            OP_AND: begin
                rw = 1'b1;
                rv = vx & vy;
            end
            OP_XOR: begin
                rw = 1'b1;
                rv = vx ^ vy;
            end
            OP_ADD_R: begin
                rw = 1'b1;
                rv = sum[7:0];
                fw = 1'b1;
                fv = sum[8];
            end
            OP_SUB_R: begin
                rw = 1'b1;
                rv = vx - vy;
                fw = 1'b1;
                fv = (vx >= vy);
            end
            OP_LDI: idx_new = ex_item_reg.nnn;
            OP_JP0: nxt = {4'h0, v0_reg} + ex_item_reg.nnn;
            default: unh = 1'b1;
        endcase
    end

    always_comb begin
        res.next_pc       = nxt;
        res.index_value   = idx_new;
        res.reg_write     = rw;
        res.reg_number    = rw ? ex_item_reg.x : 4'h0;
        res.reg_value     = rw ? rv : 8'h00;
        res.flag_write    = fw;
        res.flag_value    = fw ? fv : 1'b0;
        res.clear_display = clr;
        res.unhandled     = unh;
    end

    assign mem_we = ex_fire && rw && (ex_item_reg.x != REG_FLAG);

    always_comb begin
        pc_next  = ex_fire ? nxt : pc_reg;
        idx_next = ex_fire ? idx_new : idx_reg;
        sp_next  = ex_fire ? sp_new : sp_reg;
        v0_next  = (mem_we && ex_item_reg.x == 4'h0) ? rv : v0_reg;
        vf_next  = vf_reg;
        if (ex_fire && fw) begin
            vf_next = {7'b0, fv};
        end else if (ex_fire && rw && ex_item_reg.x == REG_FLAG) begin
            vf_next = rv;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= PC_RESET;
            idx_reg       <= '0;
            sp_reg        <= '0;
            v0_reg        <= '0;
            vf_reg        <= '0;
            vvalid_reg    <= '0;
            fwd_valid_reg <= 1'b0;
            rdx_ok_reg    <= 1'b0;
            rdy_ok_reg    <= 1'b0;
            for (int i = 0; i < STACK_DEPTH; i++) begin
                stack_reg[i] <= '0;
            end
        end else begin
            pc_reg  <= pc_next;
            idx_reg <= idx_next;
            sp_reg  <= sp_next;
            v0_reg  <= v0_next;
            vf_reg  <= vf_next;
            if (load) begin
                ex_valid_reg <= 1'b1;
                rdx_ok_reg   <= vvalid_reg[in_item.x];
                rdy_ok_reg   <= vvalid_reg[in_item.y];
            end else if (ex_fire) begin
                ex_valid_reg <= 1'b0;
            end
            if (ex_fire) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (mem_we) begin
                vvalid_reg[ex_item_reg.x] <= 1'b1;
                fwd_valid_reg             <= 1'b1;
            end
            if (ex_fire && push) begin
                stack_reg[sp_reg] <= pc_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ex_item_reg <= in_item;
        end
        if (ex_fire) begin
            out_reg <= res;
        end
        if (mem_we) begin
            fwd_addr_reg <= ex_item_reg.x;
            fwd_data_reg <= rv;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            vreg_mem[ex_item_reg.x] <= rv;
        end
        if (load) begin
            rdx_reg <= vreg_mem[in_item.x];
            rdy_reg <= vreg_mem[in_item.y];
        end
    end

endmodule

/* src/chip8_instruction_executor.sv */
// CHIP-8 instruction executor top level: decode, queue, execute.
//
//   channel  | ports                          | carries
//   ---------+--------------------------------+-------------------------------
//   input    | s_valid s_ready s_instruction  | one 16-bit opcode per transaction
//   result   | m_valid m_ready m_*            | one result per instruction
//
// One instruction retires per cycle when the result side keeps up; the execute
// stage, with its single state update per cycle, sets that rate. A result passes
// through the queue entry, the register read and the result register before it
// is presented. Reset clears the machine state and all of the valid flags;
// the register file resets by per-entry valid bits, so no clearing pass is needed.
// Either side may stall; the two-entry queue and the result register absorb it.
module chip8_instruction_executor
    import c8ie_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_instruction,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_next_pc,
    output logic [11:0] m_index_value,
    output logic        m_reg_write,
    output logic [3:0]  m_reg_number,
    output logic [7:0]  m_reg_value,
    output logic        m_flag_write,
    output logic        m_flag_value,
    output logic        m_clear_display,
    output logic        m_unhandled
);

    item_t   dec_item;
    item_t   q_item;
    logic    q_valid, q_ready;
    result_t result;

    c8ie_front u_front (
        .instruction (s_instruction),
        .item        (dec_item)
    );

    c8ie_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (dec_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    c8ie_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_item    (q_item),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (result)
    );

    assign m_next_pc       = result.next_pc;
    assign m_index_value   = result.index_value;
    assign m_reg_write     = result.reg_write;
    assign m_reg_number    = result.reg_number;
    assign m_reg_value     = result.reg_value;
    assign m_flag_write    = result.flag_write;
    assign m_flag_value    = result.flag_value;
    assign m_clear_display = result.clear_display;
    assign m_unhandled     = result.unhandled;

`ifndef SYNTHESIS
    a_unhandled_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_unhandled |-> !m_reg_write && !m_flag_write && !m_clear_display)
        else $error("unhandled opcode reported side effects");

    a_flag_with_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_flag_write |-> m_reg_write)
        else $error("flag write without register write");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");
`endif

endmodule

/* tb/chip8_result_checker.sv */
// Result checker for the CHIP-8 instruction executor: predicts every result and compares it.
`timescale 1ns / 1ps

module chip8_result_checker
    import c8ie_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [15:0] s_instruction,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [11:0] m_next_pc,
    input  logic [11:0] m_index_value,
    input  logic        m_reg_write,
    input  logic [3:0]  m_reg_number,
    input  logic [7:0]  m_reg_value,
    input  logic        m_flag_write,
    input  logic        m_flag_value,
    input  logic        m_clear_display,
    input  logic        m_unhandled,
    output int          errors,
    output int          pending,
    output int          results_checked,
    output int          kinds_covered
);

    // architectural state of the executor, as the predictor sees it
    logic [11:0] pc_q;
    logic [11:0] idx_q;
    logic [7:0]  vreg   [16];
    logic [11:0] rstack [16];
    logic [3:0]  sp_q;
    logic [31:0] seen_ops;

    result_t expected_results[$];

    initial begin
        errors          = 0;
        pending         = 0;
        results_checked = 0;
        kinds_covered   = 0;
        seen_ops        = '0;
    end

    // Executes one instruction against the predictor state; returns the result it must produce.
    function automatic result_t execute_instruction(input logic [15:0] ins);
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  n;
        logic [7:0]  kk;
        logic [11:0] nnn;
        logic [7:0]  vx;
        logic [7:0]  vy;
        logic [8:0]  sum;
        op_t         op;
        result_t     r;
        x   = ins[11:8];
        y   = ins[7:4];
        n   = ins[3:0];
        kk  = ins[7:0];
        nnn = ins[11:0];
        vx  = vreg[x];
        vy  = vreg[y];
        case (ins[15:12])
            GRP_SYS: begin
                if (n == SYS_CLS) op = OP_CLS;
                else if (n == SYS_RET) op = OP_RET;
                else op = OP_UNH;
            end
            GRP_JP:    op = OP_JP;
            GRP_CALL:  op = OP_CALL;
            GRP_SE_K:  op = OP_SE_K;
            GRP_SNE_K: op = OP_SNE_K;
            GRP_SE_R:  op = OP_SE_R;
            GRP_LD_K:  op = OP_LD_K;
            GRP_ADD_K: op = OP_ADD_K;
            GRP_ALU: begin
                case (n)
                    ALU_MOV: op = OP_MOV;
                    ALU_OR:  op = OP_OR;
                    ALU_AND: op = OP_AND;
                    ALU_XOR: op = OP_XOR;
                    ALU_ADD: op = OP_ADD_R;
                    ALU_SUB: op = OP_SUB_R;
                    default: op = OP_UNH;
                endcase
            end
            GRP_SNE_R: op = OP_SNE_R;
            GRP_LDI:   op = OP_LDI;
            GRP_JP0:   op = OP_JP0;
            default:   op = OP_UNH;
        endcase
        seen_ops[op] = 1'b1;

        r = '0;
        r.next_pc = pc_q + 12'd2;
        case (op)
            OP_CLS: r.clear_display = 1'b1;
            OP_RET: begin
                // depth is 16, so the 4-bit pointer wraps on underflow by itself
                sp_q      = sp_q - 4'd1;
                r.next_pc = rstack[sp_q] + 12'd2;
            end
            OP_JP: r.next_pc = nnn;
            OP_CALL: begin
                rstack[sp_q] = pc_q;
                sp_q         = sp_q + 4'd1;
                r.next_pc    = nnn;
            end
            OP_SE_K:  if (vx == kk) r.next_pc = pc_q + 12'd4;
            OP_SNE_K: if (vx != kk) r.next_pc = pc_q + 12'd4;
            OP_SE_R:  if (vx == vy) r.next_pc = pc_q + 12'd4;
            OP_SNE_R: if (vx != vy) r.next_pc = pc_q + 12'd4;
            OP_LD_K: begin
                r.reg_write = 1'b1;
                r.reg_value = kk;
            end
            OP_ADD_K: begin
                r.reg_write = 1'b1;
                r.reg_value = vx + kk;
            end
            OP_MOV: begin
                r.reg_write = 1'b1;
                r.reg_value = vy;
            end
            OP_OR: begin
                r.reg_write = 1'b1;
                r.reg_value = vx | vy;
            end
            OP_AND: begin
                r.reg_write = 1'b1;
                r.reg_value = vx & vy;
            end
            OP_XOR: begin
                r.reg_write = 1'b1;
                r.reg_value = vx ^ vy;
            end
            OP_ADD_R: begin
                sum          = {1'b0, vx} + {1'b0, vy};
                r.reg_write  = 1'b1;
                r.reg_value  = sum[7:0];
                r.flag_write = 1'b1;
                r.flag_value = sum[8];
            end
            OP_SUB_R: begin
                r.reg_write  = 1'b1;
                r.reg_value  = vx - vy;
                r.flag_write = 1'b1;
                r.flag_value = (vx >= vy);
            end
            OP_LDI: idx_q = nnn;
            OP_JP0: r.next_pc = {4'h0, vreg[0]} + nnn;
            default: r.unhandled = 1'b1;
        endcase

        // flag lands after the result, so VF keeps the flag when x is VF
        if (r.reg_write) begin
            vreg[x]      = r.reg_value;
            r.reg_number = x;
        end
        if (r.flag_write) vreg[REG_FLAG] = {7'h00, r.flag_value};
        pc_q          = r.next_pc;
        r.index_value = idx_q;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [11:0] want,
                                 input logic [11:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        result_t exp_r;
        if (!aresetn) begin
            pc_q  = PC_RESET;
            idx_q = '0;
            sp_q  = '0;
            for (int i = 0; i < 16; i++) begin
                vreg[i]   = '0;
                rstack[i] = '0;
            end
            expected_results.delete();
        end else begin
            // results always leave after their instruction is accepted, so check first
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no instruction outstanding");
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    compare_field("next_pc", exp_r.next_pc, m_next_pc);
                    compare_field("index_value", exp_r.index_value, m_index_value);
                    compare_field("reg_write", 12'(exp_r.reg_write), 12'(m_reg_write));
                    compare_field("reg_number", 12'(exp_r.reg_number), 12'(m_reg_number));
                    compare_field("reg_value", 12'(exp_r.reg_value), 12'(m_reg_value));
                    compare_field("flag_write", 12'(exp_r.flag_write), 12'(m_flag_write));
                    compare_field("flag_value", 12'(exp_r.flag_value), 12'(m_flag_value));
                    compare_field("clear_display", 12'(exp_r.clear_display),
                                  12'(m_clear_display));
                    compare_field("unhandled", 12'(exp_r.unhandled), 12'(m_unhandled));
                    results_checked++;
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(execute_instruction(s_instruction));
        end
        pending       = expected_results.size();
        kinds_covered = $countones(seen_ops);
    end

endmodule

/* tb/tb.sv */
// Testbench top for the CHIP-8 instruction executor: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb
    import c8ie_pkg::*;
();

    localparam int ITEMS_PER_PHASE = 375;
    localparam int STALL_LIMIT     = 2000;

    // opcode forms the executor leaves unimplemented
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;
    localparam logic [3:0] GRP_RND  = 4'hC;
    localparam logic [3:0] GRP_DRW  = 4'hD;
    localparam logic [3:0] GRP_KEY  = 4'hE;
    localparam logic [3:0] GRP_MISC = 4'hF;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [15:0] s_instruction = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [11:0] m_next_pc;
    logic [11:0] m_index_value;
    logic        m_reg_write;
    logic [3:0]  m_reg_number;
    logic [7:0]  m_reg_value;
    logic        m_flag_write;
    logic        m_flag_value;
    logic        m_clear_display;
    logic        m_unhandled;

    int errors;
    int pending;
    int results_checked;
    int kinds_covered;
    int n_accepted    = 0;
    int idle_cycles   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int send_burst    = 0;
    int recv_burst    = 0;
    int n_directed;

    logic [15:0] instr_q[$];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    chip8_instruction_executor u_top (.*);

    chip8_result_checker u_checker (.*);

    always_ff @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) n_accepted <= n_accepted + 1;
    end

    // watchdog: cycles in which neither channel completes a transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side back-pressure, with occasional stretches of steady ready
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready = 1'b0;
        end else if (recv_burst > 0) begin
            recv_burst--;
            m_ready = 1'b1;
        end else if ($urandom_range(0, 99) < 3) begin
            recv_burst = $urandom_range(10, 40);
            m_ready    = 1'b1;
        end else begin
            m_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // byte values that make equal-compare skips and carries likely
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'h7F;
            3:       return 8'h80;
            4:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] random_instruction();
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  n;
        logic [11:0] nnn;
        int          r;
        x   = 4'($urandom);
        y   = 4'($urandom);
        nnn = 12'($urandom);
        r   = $urandom_range(0, 99);
        if (r < 5) begin
            case ($urandom_range(0, 2))
                0:       n = SYS_CLS;
                1:       n = SYS_RET;
                default: n = 4'($urandom);
            endcase
            return {GRP_SYS, x, y, n};
        end
        if (r < 9)  return {GRP_JP, nnn};
        if (r < 13) return {GRP_CALL, nnn};
        if (r < 19) return {GRP_SE_K, x, pick_byte()};
        if (r < 25) return {GRP_SNE_K, x, pick_byte()};
        if (r < 30) return {GRP_SE_R, x, y, 4'($urandom)};
        if (r < 35) return {GRP_SNE_R, x, y, 4'($urandom)};
        if (r < 47) return {GRP_LD_K, x, pick_byte()};
        if (r < 55) return {GRP_ADD_K, x, pick_byte()};
        if (r < 80) begin
            if ($urandom_range(0, 3) == 0) n = 4'($urandom);
            else n = 4'($urandom_range(ALU_MOV, ALU_SUB));
            return {GRP_ALU, x, y, n};
        end
        if (r < 85) return {GRP_LDI, nnn};
        if (r < 89) return {GRP_JP0, nnn};
        return {4'($urandom_range(GRP_RND, GRP_MISC)), nnn};
    endfunction

    // either one random instruction or a nested call/return sequence with filler
    task automatic refill();
        int depth;
        if ($urandom_range(0, 99) < 4) begin
            depth = $urandom_range(1, 20);
            for (int i = 0; i < depth; i++) begin
                instr_q.push_back({GRP_CALL, 12'($urandom)});
                if ($urandom_range(0, 1)) instr_q.push_back(random_instruction());
            end
            for (int i = 0; i < depth; i++) begin
                instr_q.push_back({GRP_SYS, 8'($urandom), SYS_RET});
                if ($urandom_range(0, 1)) instr_q.push_back(random_instruction());
            end
        end else begin
            instr_q.push_back(random_instruction());
        end
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_instr(input logic [15:0] ins);
        int seen;
        if (send_burst > 0) begin
            send_burst--;
        end else if ($urandom_range(0, 99) < 3) begin
            send_burst = $urandom_range(10, 40);
        end else begin
            while ($urandom_range(0, 99) < send_idle_pct) begin
                s_valid = 1'b0;
                @(negedge aclk);
            end
        end
        s_valid       = 1'b1;
        s_instruction = ins;
        seen          = n_accepted;
        do @(negedge aclk); while (n_accepted == seen);
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        send_idle_pct = 26;
        recv_idle_pct = 56;
        instr_q = '{
            {GRP_SYS, 8'h00, SYS_CLS},
            {GRP_SYS, 8'h0E, SYS_RET},          // return on an empty stack
            {GRP_SYS, 8'h12, 4'h3},             // zero-group stub
            {GRP_CALL, 12'hFFF},
            {GRP_SYS, 8'h0E, SYS_RET},
            {GRP_JP, 12'hFFE},
            {GRP_SE_K, 4'h0, 8'h00},            // skip past the top of memory
            {GRP_LD_K, 4'hA, 8'hFF},
            {GRP_LD_K, 4'hB, 8'h01},
            {GRP_ALU, 4'hA, 4'hB, ALU_ADD},     // carry out
            {GRP_ALU, 4'hA, 4'hB, ALU_SUB},     // borrow
            {GRP_LD_K, REG_FLAG, 8'h80},
            {GRP_ALU, REG_FLAG, REG_FLAG, ALU_ADD},
            {GRP_ALU, REG_FLAG, 4'hA, ALU_SUB},
            {GRP_ADD_K, 4'hA, 8'hFF},           // wraps, no flag
            {GRP_ALU, 4'hA, 4'hB, ALU_OR},
            {GRP_ALU, 4'hA, 4'hB, ALU_AND},
            {GRP_ALU, 4'hA, 4'hB, ALU_XOR},
            {GRP_ALU, 4'hA, 4'hB, ALU_MOV},
            {GRP_SNE_K, 4'hA, 8'h00},
            {GRP_SE_R, 4'hA, 4'hB, 4'h7},       // low nibble ignored
            {GRP_SNE_R, 4'hA, 4'hB, 4'h0},
            {GRP_LDI, 12'hFFF},
            {GRP_LD_K, 4'h0, 8'hFF},
            {GRP_JP0, 12'hFFF},                 // offset jump wraps
            {GRP_ALU, 4'h1, 4'h2, ALU_SHR},
            {GRP_ALU, 4'h1, 4'h2, ALU_SUBN},
            {GRP_ALU, 4'h1, 4'h2, ALU_SHL},
            {GRP_RND, 12'h5A3},
            {GRP_DRW, 12'h123},
            {GRP_KEY, 12'h19E},
            {GRP_MISC, 12'h155}
        };
        n_directed = instr_q.size();
        while (instr_q.size() != 0) send_instr(instr_q.pop_front());
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 26;
                    recv_idle_pct = 56;
                end
                1: begin
                    send_idle_pct = 56;
                    recv_idle_pct = 26;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (instr_q.size() == 0) refill();
                send_instr(instr_q.pop_front());
                if ($urandom_range(0, 99) == 0) drain();
            end
            drain();
        end

        repeat (8) @(negedge aclk);
        $display("Ran %0d instructions (%0d directed) over three pacing phases;",
                 n_accepted, n_directed);
        $display("%0d results compared, %0d of %0d instruction kinds decoded, nested calls too.",
                 results_checked, kinds_covered, int'(OP_UNH) + 1);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
